// File: hdl/ffgrp_pkg.sv
// shared constants, register and op codes, and the grid port struct of the rectangle placer
// no dependencies
package ffgrp_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;
    localparam int ID_BITS     = 8;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int IDX_W       = $clog2(CELLS);
    localparam int DIM_W       = 5;
    localparam int POS_W       = 4;
    localparam int PIDX_W      = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PROBE  = 2'd2;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ID_BITS-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
        logic               clr;
        logic [IDX_W-1:0]   clr_addr;
    } grid_req_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: hdl/ffgrp_grid.sv
// occupancy memory of the placer: one owner id per cell, registered read
// per-cell valid flops make a never-written or cleared cell read as empty; uses ffgrp_pkg
module ffgrp_grid (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffgrp_pkg::grid_req_t        req,
    output logic [ffgrp_pkg::ID_BITS-1:0] rdata
);
    import ffgrp_pkg::*;

    logic [ID_BITS-1:0] mem [CELLS];
    logic [CELLS-1:0]   valid_reg;
    logic [ID_BITS-1:0] rd_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= valid_reg[req.raddr];
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.clr)
            begin
                valid_reg[req.clr_addr] <= 1'b0;
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

// File: hdl/ffgrp_div.sv
// restoring divider that splits a probe cell index into row and column, one bit a cycle
// uses ffgrp_pkg
module ffgrp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ffgrp_pkg::PIDX_W-1:0]  dividend,
    input  logic [ffgrp_pkg::DIM_W-1:0]   divisor,
    output logic                          done,
    output logic [ffgrp_pkg::PIDX_W-1:0]  quotient,
    output logic [ffgrp_pkg::POS_W-1:0]   remainder
);
    import ffgrp_pkg::*;

    logic [3:0]        cnt_reg;
    logic              active_reg;
    logic              done_reg;
    logic [PIDX_W-1:0] dvd_reg;
    logic [DIM_W-1:0]  rem_reg;
    logic [DIM_W-1:0]  trial;
    logic              take;

    assign trial = {rem_reg[DIM_W-2:0], dvd_reg[PIDX_W-1]};
    assign take  = (trial >= divisor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
                done_reg   <= 1'b0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(PIDX_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    // quotient bits shift into the low end of the dividend register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            dvd_reg <= {dvd_reg[PIDX_W-2:0], take};
            rem_reg <= take ? (trial - divisor) : trial;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg[POS_W-1:0];

endmodule

// File: hdl/first_fit_grid_rect_placer.sv
// first-fit rectangle placer on an occupancy grid held in a one-port-read memory
// add: a bounds check per position (S_POS), then a read and a compare per cell tested (S_RD, S_CMP),
// then one write per stamped cell (S_STAMP), rescanning with the extents swapped if nothing fits
// remove: a sweep with one memory read per cell; probe: the divider, then the cell test
// done pulses in the cycle after the last step, busy low again in that cycle; results cannot stall
// reset clears every cell through valid flops at once, columns and rows return to 16
module first_fit_grid_rect_placer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic [ffgrp_pkg::ID_BITS-1:0]     item_id,
    input  logic [ffgrp_pkg::DIM_W-1:0]       item_width,
    input  logic [ffgrp_pkg::DIM_W-1:0]       item_height,
    input  logic [ffgrp_pkg::PIDX_W-1:0]      position_index,
    input  logic [ffgrp_pkg::ID_BITS-1:0]     exclude_id,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ffgrp_pkg::DIM_W-1:0]       cfg_data,
    output logic                              done,
    output logic                              ok,
    output logic                              rotated,
    output logic [ffgrp_pkg::POS_W-1:0]       place_column,
    output logic [ffgrp_pkg::POS_W-1:0]       place_row
);
    import ffgrp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_STAMP = 3'd5;
    localparam logic [2:0] S_RM    = 3'd6;

    logic [DIM_W-1:0]   columns_reg, rows_reg;
    logic [DIM_W-1:0]   nc, nr;
    logic [2:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [ID_BITS-1:0] fid_reg, fid_next;
    logic [DIM_W-1:0]   ew_reg, ew_next, eh_reg, eh_next;
    logic [POS_W-1:0]   c_reg, c_next;
    logic [PIDX_W-1:0]  r_reg, r_next;
    logic [POS_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic               rot_reg, rot_next;
    logic [IDX_W:0]     cnt_reg, cnt_next;
    logic               done_reg, ok_reg, rotated_reg;
    logic [POS_W-1:0]   pc_reg, pr_reg;

    logic               finish, fin_ok, fin_rot;
    logic               div_start, div_done;
    logic [PIDX_W-1:0]  div_q;
    logic [POS_W-1:0]   div_r;
    grid_req_t          greq;
    logic [ID_BITS-1:0] gq;

    logic               fit_bounds, last_col, last_row, last_dx, last_dy;
    logic [POS_W-1:0]   cell_col, cell_row;
    logic [IDX_W:0]     row_base;
    logic [IDX_W-1:0]   cell_addr;
    logic [IDX_W-1:0]   prev_addr;

    assign nc = clamp_dim(columns_reg, DIM_W'(MAX_COLUMNS));
    assign nr = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= DIM_W'(MAX_COLUMNS);
            rows_reg    <= DIM_W'(MAX_ROWS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLUMNS: columns_reg <= cfg_data;
                REG_ROWS:    rows_reg    <= cfg_data;
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    ffgrp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (position_index),
        .divisor   (nc),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    ffgrp_grid u_grid (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (greq),
        .rdata (gq)
    );

    // rectangle bounds at the current top-left position
    assign fit_bounds = (ew_reg != '0) && (eh_reg != '0)
                        && ({1'b0, c_reg} < nc) && (r_reg < PIDX_W'(nr))
                        && (ew_reg <= nc - {1'b0, c_reg})
                        && (PIDX_W'(eh_reg) <= PIDX_W'(nr) - r_reg);

    assign last_col = ({1'b0, c_reg} + DIM_W'(1)) == nc;
    assign last_row = (r_reg + PIDX_W'(1)) == PIDX_W'(nr);
    assign last_dx  = ({1'b0, dx_reg} + DIM_W'(1)) == ew_reg;
    assign last_dy  = ({1'b0, dy_reg} + DIM_W'(1)) == eh_reg;

    assign cell_col  = c_reg + dx_reg;
    assign cell_row  = r_reg[POS_W-1:0] + dy_reg;
    assign row_base  = (IDX_W + 1)'(cell_row) * (IDX_W + 1)'(nc);
    assign cell_addr = IDX_W'(row_base + (IDX_W + 1)'(cell_col));
    assign prev_addr = IDX_W'(cnt_reg - (IDX_W + 1)'(1));

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        fid_next   = fid_reg;
        ew_next    = ew_reg;
        eh_next    = eh_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        rot_next   = rot_reg;
        cnt_next   = cnt_reg;
        finish     = 1'b0;
        fin_ok     = 1'b0;
        fin_rot    = 1'b0;
        div_start  = 1'b0;
        greq       = '0;
        greq.raddr = cell_addr;
        greq.waddr = cell_addr;
        greq.wdata = id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    id_next  = item_id;
                    ew_next  = item_width;
                    eh_next  = item_height;
                    c_next   = '0;
                    r_next   = '0;
                    dx_next  = '0;
                    dy_next  = '0;
                    rot_next = 1'b0;
                    cnt_next = '0;
                    fid_next = '0;
                    priority if (op == OP_ADD)
                    begin
                        state_next = (item_id == '0) ? S_RM : S_POS;
                    end
                    else if (op == OP_REMOVE)
                    begin
                        state_next = S_RM;
                    end
                    else if (op == OP_PROBE)
                    begin
                        fid_next   = exclude_id;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        // unknown op passes through the sweep state and reports zeros
                        cnt_next   = (IDX_W + 1)'(CELLS);
                        state_next = S_RM;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    c_next     = div_r;
                    r_next     = div_q;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                dx_next = '0;
                dy_next = '0;
                if (fit_bounds)
                begin
                    state_next = S_RD;
                end
                else if (op_reg == OP_PROBE)
                begin
                    finish = 1'b1;
                end
                else if (!(last_col && last_row))
                begin
                    c_next = last_col ? '0 : c_reg + POS_W'(1);
                    r_next = last_col ? r_reg + PIDX_W'(1) : r_reg;
                end
                else if (!rot_reg)
                begin
                    // rescan with the extents swapped
                    rot_next = 1'b1;
                    ew_next  = eh_reg;
                    eh_next  = ew_reg;
                    c_next   = '0;
                    r_next   = '0;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (gq != '0 && gq != fid_reg)
                begin
                    if (op_reg == OP_PROBE)
                    begin
                        finish = 1'b1;
                    end
                    else if (!(last_col && last_row))
                    begin
                        c_next     = last_col ? '0 : c_reg + POS_W'(1);
                        r_next     = last_col ? r_reg + PIDX_W'(1) : r_reg;
                        state_next = S_POS;
                    end
                    else if (!rot_reg)
                    begin
                        rot_next   = 1'b1;
                        ew_next    = eh_reg;
                        eh_next    = ew_reg;
                        c_next     = '0;
                        r_next     = '0;
                        state_next = S_POS;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (!last_dx)
                begin
                    dx_next    = dx_reg + POS_W'(1);
                    state_next = S_RD;
                end
                else if (!last_dy)
                begin
                    dx_next    = '0;
                    dy_next    = dy_reg + POS_W'(1);
                    state_next = S_RD;
                end
                else if (op_reg == OP_PROBE)
                begin
                    finish = 1'b1;
                    fin_ok = 1'b1;
                end
                else
                begin
                    dx_next    = '0;
                    dy_next    = '0;
                    state_next = S_STAMP;
                end
            end
            S_STAMP:
            begin
                greq.we = 1'b1;
                if (!last_dx)
                begin
                    dx_next = dx_reg + POS_W'(1);
                end
                else if (!last_dy)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + POS_W'(1);
                end
                else
                begin
                    finish  = 1'b1;
                    fin_ok  = 1'b1;
                    fin_rot = rot_reg;
                end
            end
            S_RM:
            begin
                // read one cell ahead, compare the cell read last cycle
                greq.raddr    = cnt_reg[IDX_W-1:0];
                greq.clr_addr = prev_addr;
                greq.clr      = (op_reg == OP_REMOVE) && (cnt_reg != '0) && (gq == id_reg);
                if (cnt_reg == (IDX_W + 1)'(CELLS))
                begin
                    finish = 1'b1;
                    fin_ok = (op_reg == OP_REMOVE);
                end
                else
                begin
                    cnt_next = cnt_reg + (IDX_W + 1)'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            rotated_reg <= 1'b0;
            pc_reg      <= '0;
            pr_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (finish)
            begin
                ok_reg      <= fin_ok;
                rotated_reg <= fin_rot;
                pc_reg      <= (fin_ok && op_reg == OP_ADD) ? c_reg : '0;
                pr_reg      <= (fin_ok && op_reg == OP_ADD) ? r_reg[POS_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        id_reg  <= id_next;
        fid_reg <= fid_next;
        ew_reg  <= ew_next;
        eh_reg  <= eh_next;
        c_reg   <= c_next;
        r_reg   <= r_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        rot_reg <= rot_next;
        cnt_reg <= cnt_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign ok           = ok_reg;
    assign rotated      = rotated_reg;
    assign place_column = pc_reg;
    assign place_row    = pr_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_rot_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && rotated |-> ok)
        else $error("rotated without placement");

    a_nonadd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && op_reg != OP_ADD |-> !rotated && place_column == '0 && place_row == '0)
        else $error("position reported for a non-add item");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_stamp_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STAMP |-> id_reg != '0 && op_reg == OP_ADD)
        else $error("stamp with empty id or wrong op");
`endif

endmodule
